// ----- rtl/arp_icmp_echo_responder_macros.svh -----
// Assertion macros shared by the responder RTL.
// Each use stands on a line of its own and carries its own semicolon.
`ifndef ARP_ICMP_ECHO_RESPONDER_MACROS_SVH
`define ARP_ICMP_ECHO_RESPONDER_MACROS_SVH

`ifndef SYNTHESIS
`define AER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AER_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AER_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/aer_pkg.sv -----
package aer_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;

    // Configuration register file.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAC_W;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = CFG_IDX_W'(1);
    localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'd43838865666;
    localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'd3232236040;

    typedef struct packed {
        logic [MAC_W-1:0] own_mac;
        logic [IP_W-1:0]  own_ip;
    } t_cfg;

    // One queue entry holds the reply bytes released by one received byte.
    localparam int JOB_SLOTS = 3;
    localparam int SLOT_W    = $clog2(JOB_SLOTS + 1);

    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0] bytes;
        logic [SLOT_W-1:0]         cnt;
        logic                      fin;
        logic                      ok;
    } t_job;

    // Queue depth must be a power of two so the pointers wrap on their own.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

// ----- rtl/aer_ifs.sv -----
interface aer_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_end;

    modport source (output valid, output rx_byte, output rx_end, input ready);
    modport sink   (input valid, input rx_byte, input rx_end, output ready);
endinterface

interface aer_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_end;
    logic       reply_ok;

    modport source (output valid, output tx_byte, output tx_end, output reply_ok,
                    input ready);
    modport sink   (input valid, input tx_byte, input tx_end, input reply_ok,
                    output ready);
endinterface

interface aer_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aer_pkg::CFG_IDX_W-1:0]    index;
    logic [aer_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/aer_cfg_regs.sv -----
module aer_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aer_cfg_if.sink       i_cfg,
    output aer_pkg::t_cfg o_cfg
);

    logic [aer_pkg::MAC_W-1:0] r_own_mac;
    logic [aer_pkg::IP_W-1:0]  r_own_ip;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= aer_pkg::OWN_MAC_RESET;
            r_own_ip  <= aer_pkg::OWN_IP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                aer_pkg::REG_OWN_MAC: r_own_mac <= i_cfg.data[aer_pkg::MAC_W-1:0];
                aer_pkg::REG_OWN_IP:  r_own_ip  <= i_cfg.data[aer_pkg::IP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.own_mac = r_own_mac;
    assign o_cfg.own_ip  = r_own_ip;

endmodule

// ----- rtl/aer_front.sv -----
`include "arp_icmp_echo_responder_macros.svh"

module aer_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aer_rx_if.sink        i_rx,
    input  aer_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output aer_pkg::t_job o_job
);

    localparam int PW = aer_pkg::POS_W;

    // Byte offsets within the frame.
    localparam logic [PW-1:0] P_LAG        = PW'(6);
    localparam logic [PW-1:0] P_LAG_M1     = PW'(5);
    localparam logic [PW-1:0] P_LAG_M2     = PW'(4);
    localparam logic [PW-1:0] P_SMAC_END   = PW'(12);
    localparam logic [PW-1:0] P_ETYPE_LO   = PW'(13);
    localparam logic [PW-1:0] P_ARP_OP_LO  = PW'(21);
    localparam logic [PW-1:0] P_ARP_SHA    = PW'(22);
    localparam logic [PW-1:0] P_ARP_SPA    = PW'(28);
    localparam logic [PW-1:0] P_ARP_THA    = PW'(32);
    localparam logic [PW-1:0] P_ARP_TPA    = PW'(38);
    localparam logic [PW-1:0] P_ARP_TPA_LS = PW'(41);
    localparam logic [PW-1:0] P_ARP_END    = PW'(42);
    localparam logic [PW-1:0] P_IP_PROTO   = PW'(23);
    localparam logic [PW-1:0] P_IP_SRC     = PW'(26);
    localparam logic [PW-1:0] P_IP_DST     = PW'(30);
    localparam logic [PW-1:0] P_IP_END     = PW'(34);
    localparam logic [PW-1:0] P_ICMP_TYPE  = PW'(34);
    localparam logic [PW-1:0] P_ICMP_CK_LO = PW'(37);
    localparam logic [PW-1:0] P_LAST       = PW'(aer_pkg::MAX_FRAME_BYTES - 1);

    localparam logic [15:0] ETYPE_ARP         = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4        = 16'h0800;
    localparam logic [7:0]  IP_PROTO_ICMP     = 8'h01;
    localparam logic [7:0]  ICMP_ECHO_REQ     = 8'h08;
    localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'h00;
    localparam logic [15:0] ARP_OP_REQ        = 16'h0001;
    localparam logic [15:0] ARP_OP_REQ_SWAP   = 16'h0100;
    localparam logic [15:0] ARP_OP_REPLY      = 16'h0002;
    localparam logic [15:0] ARP_OP_REPLY_SWAP = 16'h0200;
    localparam logic [15:0] CKSUM_ADJ         = 16'h0800;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_ARP,
        KIND_IPV4,
        KIND_ICMP
    } t_kind;

    logic [7:0]                r_dly [6];
    logic [PW-1:0]             r_pos;
    t_kind                     r_kind;
    logic [aer_pkg::MAC_W-1:0] r_smac;
    logic [aer_pkg::IP_W-1:0]  r_sip;
    logic                      r_echo;
    logic                      r_tmatch;

    t_kind                     n_kind;
    logic [aer_pkg::MAC_W-1:0] n_smac;
    logic [aer_pkg::IP_W-1:0]  n_sip;
    logic                      n_echo;
    logic                      n_tmatch;
    logic [7:0]                n_prev;
    logic [7:0]                n_cur;

    logic                      accept;
    logic [PW-1:0]             tpa_off;
    logic                      tpa_eq;
    logic [16:0]               cksum_sum;
    logic [15:0]               cksum_fold;
    logic [7:0]                out6;
    logic [7:0]                out5;
    logic [7:0]                out4;
    aer_pkg::t_job             job;

    function automatic logic [7:0] f_mac_byte(input logic [aer_pkg::MAC_W-1:0] mac,
                                              input logic [2:0] idx);
        return mac[8 * (5 - int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] f_ip_byte(input logic [aer_pkg::IP_W-1:0] ip,
                                             input logic [1:0] idx);
        return ip[8 * (3 - int'(idx)) +: 8];
    endfunction

    // Reply byte at offset k; dst is what goes into the destination MAC field.
    function automatic logic [7:0] f_rewrite(
        input logic [PW-1:0]             k,
        input logic [7:0]                v,
        input logic [7:0]                dst,
        input t_kind                     kind,
        input aer_pkg::t_cfg             cfg,
        input logic [aer_pkg::MAC_W-1:0] smac,
        input logic [aer_pkg::IP_W-1:0]  sip
    );
        logic [PW-1:0] off;
        logic [7:0]    res;
        res = v;
        off = '0;
        if (k < P_LAG) begin
            res = dst;
        end else if (k < P_SMAC_END) begin
            off = k - P_LAG;
            res = f_mac_byte(cfg.own_mac, off[2:0]);
        end else if (kind == KIND_ARP) begin
            if (k >= P_ARP_SHA && k < P_ARP_SPA) begin
                off = k - P_ARP_SHA;
                res = f_mac_byte(cfg.own_mac, off[2:0]);
            end else if (k >= P_ARP_SPA && k < P_ARP_THA) begin
                off = k - P_ARP_SPA;
                res = f_ip_byte(cfg.own_ip, off[1:0]);
            end else if (k >= P_ARP_THA && k < P_ARP_TPA) begin
                off = k - P_ARP_THA;
                res = f_mac_byte(smac, off[2:0]);
            end else if (k >= P_ARP_TPA && k < P_ARP_END) begin
                off = k - P_ARP_TPA;
                res = f_ip_byte(sip, off[1:0]);
            end
        end else if (kind == KIND_ICMP) begin
            if (k >= P_IP_SRC && k < P_IP_DST) begin
                off = k - P_IP_SRC;
                res = f_ip_byte(cfg.own_ip, off[1:0]);
            end else if (k >= P_IP_DST && k < P_IP_END) begin
                off = k - P_IP_DST;
                res = f_ip_byte(sip, off[1:0]);
            end
        end
        return res;
    endfunction

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;

    assign tpa_off    = r_pos - P_ARP_TPA;
    assign tpa_eq     = i_rx.rx_byte == f_ip_byte(i_cfg.own_ip, tpa_off[1:0]);
    assign cksum_sum  = {1'b0, r_dly[5], i_rx.rx_byte} + {1'b0, CKSUM_ADJ};
    assign cksum_fold = cksum_sum[15:0] + {15'd0, cksum_sum[16]};

    always_comb begin
        n_kind = r_kind;
        if (r_pos == P_ETYPE_LO) begin
            if ({r_dly[5], i_rx.rx_byte} == ETYPE_ARP) begin
                n_kind = KIND_ARP;
            end else if ({r_dly[5], i_rx.rx_byte} == ETYPE_IPV4) begin
                n_kind = KIND_IPV4;
            end else begin
                n_kind = KIND_OTHER;
            end
        end
        if (n_kind == KIND_IPV4 && r_pos == P_IP_PROTO && i_rx.rx_byte == IP_PROTO_ICMP) begin
            n_kind = KIND_ICMP;
        end

        n_prev   = r_dly[5];
        n_cur    = i_rx.rx_byte;
        n_smac   = r_smac;
        n_sip    = r_sip;
        n_echo   = r_echo;
        n_tmatch = r_tmatch;

        case (n_kind)
            KIND_ARP: begin
                // Both byte orders of the request opcode are turned into a reply.
                if (r_pos == P_ARP_OP_LO) begin
                    if ({r_dly[5], i_rx.rx_byte} == ARP_OP_REQ) begin
                        n_cur = ARP_OP_REPLY[7:0];
                    end else if ({r_dly[5], i_rx.rx_byte} == ARP_OP_REQ_SWAP) begin
                        n_prev = ARP_OP_REPLY_SWAP[15:8];
                    end
                end
                if (r_pos >= P_ARP_SHA && r_pos < P_ARP_SPA) begin
                    n_smac = {r_smac[aer_pkg::MAC_W-9:0], i_rx.rx_byte};
                end
                if (r_pos >= P_ARP_SPA && r_pos < P_ARP_THA) begin
                    n_sip = {r_sip[aer_pkg::IP_W-9:0], i_rx.rx_byte};
                end
                if (r_pos >= P_ARP_TPA && r_pos <= P_ARP_TPA_LS) begin
                    n_tmatch = (r_pos == P_ARP_TPA) ? tpa_eq : (r_tmatch && tpa_eq);
                end
            end
            KIND_ICMP: begin
                if (r_pos >= P_IP_SRC && r_pos < P_IP_DST) begin
                    n_sip = {r_sip[aer_pkg::IP_W-9:0], i_rx.rx_byte};
                end
                if (r_pos == P_ICMP_TYPE && i_rx.rx_byte == ICMP_ECHO_REQ) begin
                    n_echo = 1'b1;
                    n_cur  = ICMP_ECHO_REPLY;
                end
                // The checksum high byte is still the newest delay entry here.
                if (r_pos == P_ICMP_CK_LO && r_echo) begin
                    n_prev = cksum_fold[15:8];
                    n_cur  = cksum_fold[7:0];
                end
            end
            default: ;
        endcase
    end

    assign out6 = f_rewrite(r_pos - P_LAG, r_dly[0], i_rx.rx_byte,
                            n_kind, i_cfg, n_smac, n_sip);
    assign out5 = f_rewrite(r_pos - P_LAG_M1, r_dly[1], 8'h00,
                            n_kind, i_cfg, n_smac, n_sip);
    assign out4 = f_rewrite(r_pos - P_LAG_M2, r_dly[2], 8'h00,
                            n_kind, i_cfg, n_smac, n_sip);

    always_comb begin
        job = '0;
        if (!i_rx.rx_end) begin
            if (r_pos >= P_LAG) begin
                job.bytes[0] = out6;
                job.cnt      = aer_pkg::SLOT_W'(1);
            end
        end else begin
            // At the frame end the bytes still in the delay line are flushed,
            // minus the four bytes of FCS.
            if (r_pos >= P_LAG) begin
                job.bytes[0] = out6;
                job.bytes[1] = out5;
                job.bytes[2] = out4;
                job.cnt      = aer_pkg::SLOT_W'(3);
            end else if (r_pos == P_LAG_M1) begin
                job.bytes[0] = out5;
                job.bytes[1] = out4;
                job.cnt      = aer_pkg::SLOT_W'(2);
            end else if (r_pos == P_LAG_M2) begin
                job.bytes[0] = out4;
                job.cnt      = aer_pkg::SLOT_W'(1);
            end
            job.fin = 1'b1;
            job.ok  = (n_kind == KIND_ARP && n_tmatch && r_pos >= P_ARP_TPA_LS) || n_echo;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_kind   <= KIND_OTHER;
            r_echo   <= 1'b0;
            r_tmatch <= 1'b0;
        end else if (accept) begin
            if (i_rx.rx_end) begin
                r_pos    <= '0;
                r_kind   <= KIND_OTHER;
                r_echo   <= 1'b0;
                r_tmatch <= 1'b0;
            end else begin
                if (r_pos != P_LAST) begin
                    r_pos <= r_pos + PW'(1);
                end
                r_kind   <= n_kind;
                r_echo   <= n_echo;
                r_tmatch <= n_tmatch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dly[0] <= r_dly[1];
            r_dly[1] <= r_dly[2];
            r_dly[2] <= r_dly[3];
            r_dly[3] <= r_dly[4];
            r_dly[4] <= n_prev;
            r_dly[5] <= n_cur;
            r_smac   <= n_smac;
            r_sip    <= n_sip;
        end
    end

    `AER_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, accept && i_rx.rx_end, r_pos == '0 && r_kind == KIND_OTHER && !r_echo)

endmodule

// ----- rtl/aer_queue.sv -----
`include "arp_icmp_echo_responder_macros.svh"

module aer_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aer_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output aer_pkg::t_job o_head
);

    localparam int AW = aer_pkg::FIFO_AW;

    aer_pkg::t_job r_mem [aer_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;

    assign o_full  = r_count == (AW + 1)'(aer_pkg::FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `AER_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `AER_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `AER_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ----- rtl/aer_back.sv -----
`include "arp_icmp_echo_responder_macros.svh"

module aer_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aer_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    aer_tx_if.source      o_tx
);

    localparam int SW = aer_pkg::SLOT_W;

    logic          r_valid;
    logic [SW-1:0] r_sub;
    logic [7:0]    r_byte;
    logic          r_end;
    logic          r_ok;

    logic          last;
    logic          load;

    // The output register takes a queued byte whenever it is empty or being drained.
    assign last  = r_sub == (i_head.cnt - SW'(1));
    assign load  = !i_empty && (!r_valid || o_tx.ready);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= last ? '0 : r_sub + SW'(1);
        end else if (o_tx.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_sub];
            r_end  <= i_head.fin && last;
            r_ok   <= i_head.ok && i_head.fin && last;
        end
    end

    assign o_tx.valid    = r_valid;
    assign o_tx.tx_byte  = r_byte;
    assign o_tx.tx_end   = r_end;
    assign o_tx.reply_ok = r_ok;

    `AER_ASSERT_IMPL(a_slot_in_entry, i_clk, i_rst_n, !i_empty, r_sub < i_head.cnt)

endmodule

// ----- rtl/arp_icmp_echo_responder.sv -----
// Channel  Port    Dir  Payload
// -------  ------  ---  -----------------------------------
// rx       i_rx    in   rx_byte[7:0], rx_end
// tx       o_tx    out  tx_byte[7:0], tx_end, reply_ok
// cfg      i_cfg   in   index[1:0], data[47:0] (0 own MAC, 1 own IP)
//
// One received byte is taken per cycle while rx ready is high; a reply byte
// passes the queue and the output register, six bytes behind in frame order.
// The byte carrying the frame end releases up to three reply bytes, which the
// output stage sends one at a time; the four-entry queue absorbs that burst.
// Reset is synchronous and restores the default MAC and IP addresses.
// A stalled tx side backs up through the queue and lowers rx ready when full.
module arp_icmp_echo_responder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    aer_rx_if.sink   i_rx,
    aer_tx_if.source o_tx,
    aer_cfg_if.sink  i_cfg
);

    aer_pkg::t_cfg cfg;
    aer_pkg::t_job push_job;
    aer_pkg::t_job head_job;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    aer_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    aer_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    aer_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    aer_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_tx    (o_tx)
    );

endmodule
